// File: sv/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants, types and the rounding helper of the box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int COORD_BITS_DEF = 20;
   localparam int Q_BITS         = 16;
   localparam int CFG_ADDR_BITS  = 2;

   // register byte addresses
   localparam logic [CFG_ADDR_BITS-1:0] ADDR_PARALLEL_CUTOFF = 2'd0;

   localparam logic [15:0] CUTOFF_RESET = 16'hFFFF;

   typedef logic signed [Q_BITS-1:0] q15_type;
   typedef q15_type [2:0][2:0] mat3_type;

   // Round a value in units of 2^-30 to Q1.15, half up, saturate to +-32767.
   function automatic q15_type to_q15(input logic signed [35:0] v);
      logic signed [36:0] t;
      logic signed [21:0] q;
      begin
         t = 37'(v) + 37'sd16384;
         q = 22'(t >>> 15);
         if (q > 22'sd32767) begin
            to_q15 = 16'sd32767;
         end else if (q < -22'sd32767) begin
            to_q15 = -16'sd32767;
         end else begin
            to_q15 = q[15:0];
         end
      end
   endfunction

endpackage

// File: sv/obb_overlap_test.sv
// An accepted req_ beat passes through all seven registered stages to its rsp_ beat.
// Throughput: one box pair per cycle while no stall is held at rsp_; every one of
// the seven stages takes a new beat each cycle unless stalled.
// A stall at rsp_ freezes all stages together; no beat is lost or repeated.
// Reset (synchronous, active high) clears the stage valid bits and sets
// parallel_cutoff to 65535.
// ----------------------------------------------------------------------------
// obb_overlap_test
// Separating-axis overlap test of two oriented boxes, fully pipelined.
// ----------------------------------------------------------------------------
module obb_overlap_test #(
   parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [3*COORD_BITS-1:0]     req_centre_a,
   input  logic [63:0]                 req_rotation_a,
   input  logic [3*COORD_BITS-1:0]     req_half_size_a,
   input  logic [3*COORD_BITS-1:0]     req_centre_b,
   input  logic [63:0]                 req_rotation_b,
   input  logic [3*COORD_BITS-1:0]     req_half_size_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_overlap,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [obb_pkg::CFG_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import obb_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int NST = 7;
   localparam int DW = CB + 1;           // centre difference
   localparam int PW = DW + 18;          // projected distance, 2^-15
   localparam int RW = CB + 18;          // face radius terms
   localparam int EW = PW + 17;          // edge products, 2^-30

   logic [15:0] cutoff_ff;
   logic        adv;
   logic [NST-1:0] vld_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == ADDR_PARALLEL_CUTOFF) begin
         cutoff_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_PARALLEL_CUTOFF) ? {16'd0, cutoff_ff} : '0;

   // pipeline advances unless the last stage holds an untaken result
   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stages 1-2: axes
   mat3_type axa, axb;
   obb_axes u_axa (.clock(clock), .en(adv), .rotation(req_rotation_a), .axes(axa));
   obb_axes u_axb (.clock(clock), .en(adv), .rotation(req_rotation_b), .axes(axb));

   // side data delay: centre differences for stages 1-2, half sizes through stage 5
   logic signed [DW-1:0] d0_in [3];
   logic signed [DW-1:0] d1_ff [3], d2_ff [3];
   logic [CB-1:0] ha1_ff [3], ha2_ff [3], ha3_ff [3], ha4_ff [3], ha5_ff [3];
   logic [CB-1:0] hb1_ff [3], hb2_ff [3], hb3_ff [3], hb4_ff [3], hb5_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d0_in[k] = DW'($signed(req_centre_a[k*CB +: CB]))
                  - DW'($signed(req_centre_b[k*CB +: CB]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            d1_ff[k] <= d0_in[k];  d2_ff[k] <= d1_ff[k];
            ha1_ff[k] <= req_half_size_a[k*CB +: CB];
            hb1_ff[k] <= req_half_size_b[k*CB +: CB];
            ha2_ff[k] <= ha1_ff[k]; ha3_ff[k] <= ha2_ff[k];
            ha4_ff[k] <= ha3_ff[k]; ha5_ff[k] <= ha4_ff[k];
            hb2_ff[k] <= hb1_ff[k]; hb3_ff[k] <= hb2_ff[k];
            hb4_ff[k] <= hb3_ff[k]; hb5_ff[k] <= hb4_ff[k];
         end
      end
   end

   // stage 3: raw dot products and projected distances
   logic signed [33:0] raw_ff [3][3];
   logic signed [PW-1:0] da3_ff [3], db3_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               raw_ff[i][j] <= 34'(axa[i][0] * axb[j][0]) + 34'(axa[i][1] * axb[j][1])
                             + 34'(axa[i][2] * axb[j][2]);
            end
            da3_ff[i] <= PW'(d2_ff[0] * axa[i][0]) + PW'(d2_ff[1] * axa[i][1])
                       + PW'(d2_ff[2] * axa[i][2]);
            db3_ff[i] <= PW'(d2_ff[0] * axb[i][0]) + PW'(d2_ff[1] * axb[i][1])
                       + PW'(d2_ff[2] * axb[i][2]);
         end
      end
   end

   // stage 4: cosines and parallel flag
   mat3_type c4_ff;
   logic [15:0] ac4_ff [3][3];
   logic par4_ff;
   logic signed [PW-1:0] da4_ff [3], db4_ff [3];
   logic par4_in;
   logic [34:0] lim;
   mat3_type c4_in;
   assign lim = 35'(cutoff_ff) << 14;
   always_comb begin
      par4_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c4_in[i][j] = to_q15(36'(raw_ff[i][j]));
            if (35'(raw_ff[i][j] < 0 ? -35'(raw_ff[i][j]) : 35'(raw_ff[i][j])) > lim) begin
               par4_in = 1'b1;
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c4_ff   <= c4_in;
         par4_ff <= par4_in;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               ac4_ff[i][j] <= c4_in[i][j] < 0 ? 16'(-c4_in[i][j]) : 16'(c4_in[i][j]);
            end
            da4_ff[i] <= da3_ff[i];
            db4_ff[i] <= db3_ff[i];
         end
      end
   end

   // stage 5: radius products and edge distance products
   logic [RW-1:0] rb5_ff [3][3];   // hb[j]*ac[i][j]
   logic [RW-1:0] ra5_ff [3][3];   // ha[i]*ac[i][j]
   logic signed [EW-1:0] e5_ff [3][3];
   logic [PW-1:0] ada5_ff [3], adb5_ff [3];
   logic par5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         par5_ff <= par4_ff;
         for (int i = 0; i < 3; i++) begin
            ada5_ff[i] <= da4_ff[i] < 0 ? PW'(-da4_ff[i]) : PW'(da4_ff[i]);
            adb5_ff[i] <= db4_ff[i] < 0 ? PW'(-db4_ff[i]) : PW'(db4_ff[i]);
            for (int j = 0; j < 3; j++) begin
               rb5_ff[i][j] <= RW'(hb4_ff[j]) * RW'(ac4_ff[i][j]);
               ra5_ff[i][j] <= RW'(ha4_ff[i]) * RW'(ac4_ff[i][j]);
               e5_ff[i][j] <= EW'(da4_ff[(i+2)%3] * c4_ff[(i+1)%3][j])
                            - EW'(da4_ff[(i+1)%3] * c4_ff[(i+2)%3][j]);
            end
         end
      end
   end

   // cosine magnitudes, delayed with stage 5
   logic [15:0] ac5_ff [3][3];
   always_ff @(posedge clock) begin
      if (adv) begin
         ac5_ff <= ac4_ff;
      end
   end

   // stage 6: all fifteen axis compares
   logic face6_in, edge6_in, face6_ff, edge6_ff, par6_ff;
   always_comb begin
      logic [RW+2:0] r0, r1;
      logic [EW-1:0] er;
      face6_in = 1'b1;
      edge6_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         r1 = (RW+3)'(rb5_ff[i][0]) + (RW+3)'(rb5_ff[i][1]) + (RW+3)'(rb5_ff[i][2]);
         if ((RW+3)'(ada5_ff[i]) > (RW+3)'({ha5_ff[i], 15'd0}) + r1) face6_in = 1'b0;
         r0 = (RW+3)'(ra5_ff[0][i]) + (RW+3)'(ra5_ff[1][i]) + (RW+3)'(ra5_ff[2][i]);
         if ((RW+3)'(adb5_ff[i]) > r0 + (RW+3)'({hb5_ff[i], 15'd0})) face6_in = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            er = e5_ff[i][j] < 0 ? EW'(-e5_ff[i][j]) : EW'(e5_ff[i][j]);
            r0 = (RW+3)'(RW'(ha5_ff[(i+1)%3]) * RW'(ac5_ff[(i+2)%3][j]))
               + (RW+3)'(RW'(ha5_ff[(i+2)%3]) * RW'(ac5_ff[(i+1)%3][j]))
               + (RW+3)'(RW'(hb5_ff[(j+1)%3]) * RW'(ac5_ff[i][(j+2)%3]))
               + (RW+3)'(RW'(hb5_ff[(j+2)%3]) * RW'(ac5_ff[i][(j+1)%3]));
            if (EW'(er) > EW'({r0, 15'd0})) edge6_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         face6_ff <= face6_in;
         edge6_ff <= edge6_in;
         par6_ff  <= par5_ff;
      end
   end

   // stage 7: combine into the result register
   logic ovl_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ovl_ff <= face6_ff && (par6_ff || edge6_ff);
      end
   end

   assign rsp_valid   = vld_ff[NST-1];
   assign rsp_overlap = ovl_ff;

endmodule

// File: sv/obb_axes.sv
// ----------------------------------------------------------------------------
// obb_axes
// Two-stage quaternion to rotation matrix unit: products, then round.
// ----------------------------------------------------------------------------
module obb_axes (
   input  logic                 clock,
   input  logic                 en,
   input  logic [63:0]          rotation,
   output obb_pkg::mat3_type    axes
);
   import obb_pkg::*;

   logic signed [31:0] p_in [10];
   logic signed [31:0] p_ff [10];
   logic signed [15:0] w, x, y, z;
   logic signed [35:0] one;
   mat3_type axes_in, axes_ff;

   assign w = rotation[15:0];
   assign x = rotation[31:16];
   assign y = rotation[47:32];
   assign z = rotation[63:48];
   assign one = 36'sd1 <<< 30;

   // form the nine quaternion products; the tenth slot is zero
   always_comb begin
      p_in[0] = x * x;  p_in[1] = y * y;  p_in[2] = z * z;
      p_in[3] = x * y;  p_in[4] = x * z;  p_in[5] = y * z;
      p_in[6] = w * x;  p_in[7] = w * y;  p_in[8] = w * z;
      p_in[9] = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   // combine and round to Q1.15
   always_comb begin
      axes_in[0][0] = to_q15(one - 36'(p_ff[1]) * 2 - 36'(p_ff[2]) * 2);
      axes_in[0][1] = to_q15((36'(p_ff[3]) + 36'(p_ff[8])) * 2);
      axes_in[0][2] = to_q15((36'(p_ff[4]) - 36'(p_ff[7])) * 2);
      axes_in[1][0] = to_q15((36'(p_ff[3]) - 36'(p_ff[8])) * 2);
      axes_in[1][1] = to_q15(one - 36'(p_ff[0]) * 2 - 36'(p_ff[2]) * 2);
      axes_in[1][2] = to_q15((36'(p_ff[5]) + 36'(p_ff[6])) * 2);
      axes_in[2][0] = to_q15((36'(p_ff[4]) + 36'(p_ff[7])) * 2);
      axes_in[2][1] = to_q15((36'(p_ff[5]) - 36'(p_ff[6])) * 2);
      axes_in[2][2] = to_q15(one - 36'(p_ff[0]) * 2 - 36'(p_ff[1]) * 2 + 36'(p_ff[9]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axes_ff <= axes_in;
      end
   end

   assign axes = axes_ff;

endmodule

// File: sv/obb_checker.sv
// ----------------------------------------------------------------------------
// obb_checker
// Port-level assertions for the box overlap test, bound to the top level.
// ----------------------------------------------------------------------------
module obb_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_overlap,
   input logic csr_pready
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_overlap))
      else $error("result dropped under stall");

   // input side stalls exactly when output is blocked
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output blocked");

   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled without cause");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   // nothing out right after reset
   a_reset: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind obb_overlap_test obb_checker u_obb_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_overlap(rsp_overlap),
   .csr_pready(csr_pready)
);
